FILE: sv/sse_pkg.sv
// ----------------------------------------------------------------------------
// Sprite skip-run encoder package
// Shared widths, register codes and the run-flush request passed from the
// run controller to the word sequencer.
// ----------------------------------------------------------------------------
package sse_pkg;

    localparam int WORD_W   = 16;
    localparam int LEN_W    = 6;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam logic [1:0] REG_BACK_COLOR = 2'd0;
    localparam logic [1:0] REG_ROW_WIDTH  = 2'd1;
    localparam logic [1:0] REG_SKIP_OP    = 2'd2;
    localparam logic [1:0] REG_RUN_OP     = 2'd3;

    localparam logic [LEN_W-1:0] ROW_WIDTH_RESET = 6'd32;
    localparam logic [LEN_W-1:0] LEN_SAT         = 6'd63;

    typedef enum logic [1:0] {
        CK_NONE,
        CK_SKIP,
        CK_LIT
    } t_close_kind;

    typedef struct packed {
        t_close_kind       kind;
        logic [LEN_W-1:0]  len;
    } t_close;

    typedef struct packed {
        logic   valid;
        t_close first;
        t_close second;
    } t_flush_req;

endpackage

FILE: sv/sse_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read. The read data
// holds its value in cycles without a read.
// ----------------------------------------------------------------------------
module sse_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/sse_run_ctrl.sv
// ----------------------------------------------------------------------------
// Sprite skip-run encoder run controller
// Classifies each pixel, tracks the open run and the column, stores literal
// pixels in the run buffer and requests the flush of closed runs.
// ----------------------------------------------------------------------------
module sse_run_ctrl
    import sse_pkg::*;
#(
    parameter int MAX_WIDTH = 32,
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [WORD_W-1:0]  i_pixel,
    input  logic [WORD_W-1:0]  i_back_color,
    input  logic [LEN_W-1:0]   i_row_width,
    output logic               o_we,
    output logic [AW-1:0]      o_waddr,
    output logic [WORD_W-1:0]  o_wdata,
    output t_flush_req         o_req
);

    typedef enum logic [1:0] {
        M_START = 2'd0,
        M_SKIP  = 2'd1,
        M_LIT   = 2'd2
    } t_mode;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_WIDTH);
    localparam logic [LEN_W-1:0] ONE     = LEN_W'(1);

    t_mode            r_mode, n_mode, mid_mode;
    logic [LEN_W-1:0] r_len, n_len, mid_len, inc_len;
    logic [LEN_W-1:0] r_col, n_col, col_next, w_eff;
    logic             is_back, eor;
    t_close           close1, close2;

    always_comb begin
        is_back     = (i_pixel == i_back_color);
        close1.kind = CK_NONE;
        close1.len  = r_len;
        mid_mode    = r_mode;
        mid_len     = r_len;
        unique case (r_mode)
            M_SKIP: begin
                if (!is_back) begin
                    close1.kind = CK_SKIP;
                    mid_mode    = M_LIT;
                    mid_len     = '0;
                end
            end
            M_LIT: begin
                if (is_back) begin
                    close1.kind = CK_LIT;
                    mid_mode    = M_SKIP;
                    mid_len     = '0;
                end
            end
            default: begin
                mid_mode = is_back ? M_SKIP : M_LIT;
                mid_len  = '0;
            end
        endcase

        inc_len = (mid_len < LEN_SAT) ? mid_len + ONE : mid_len;

        if (i_row_width == '0) begin
            w_eff = ONE;
        end else if (i_row_width > MAX_LEN) begin
            w_eff = MAX_LEN;
        end else begin
            w_eff = i_row_width;
        end
        col_next = r_col + ONE;
        eor      = (col_next >= w_eff);

        close2.kind = eor ? ((mid_mode == M_SKIP) ? CK_SKIP : CK_LIT) : CK_NONE;
        close2.len  = inc_len;

        n_mode = eor ? M_START : mid_mode;
        n_len  = eor ? '0 : inc_len;
        n_col  = eor ? '0 : col_next;

        o_we    = i_accept && (mid_mode == M_LIT) && (mid_len < MAX_LEN);
        o_waddr = mid_len[AW-1:0];
        o_wdata = i_pixel;

        o_req.valid  = i_accept && ((close1.kind != CK_NONE) || eor);
        o_req.first  = close1;
        o_req.second = close2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_START;
            r_len  <= '0;
            r_col  <= '0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_len  <= n_len;
            r_col  <= n_col;
        end
    end

endmodule

FILE: sv/sse_emitter.sv
// ----------------------------------------------------------------------------
// Sprite skip-run encoder word sequencer
// Turns closed runs into code words: opcode, count and, for literal runs,
// the buffered pixels read back from the run buffer one per unstalled cycle.
// ----------------------------------------------------------------------------
module sse_emitter
    import sse_pkg::*;
#(
    parameter int MAX_WIDTH = 32,
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_flush_req         i_req,
    input  logic [WORD_W-1:0]  i_skip_op,
    input  logic [WORD_W-1:0]  i_run_op,
    input  logic [WORD_W-1:0]  i_rdata,
    input  logic               i_stall,
    output logic               o_busy,
    output logic               o_re,
    output logic [AW-1:0]      o_raddr,
    output logic               o_valid,
    output logic [WORD_W-1:0]  o_code_word,
    output logic               o_row_first,
    output logic               o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_OP,
        S_CNT,
        S_LIT
    } t_state;

    localparam logic [LEN_W-1:0] ONE = LEN_W'(1);

    t_state            r_state, n_state;
    t_close            r_cur, n_cur, r_pend, n_pend;
    logic              r_eor, n_eor;
    logic [LEN_W-1:0]  r_idx, n_idx;
    logic              r_row_started, n_row_started;
    logic              r_ovalid, n_ovalid;
    logic [WORD_W-1:0] r_word, n_word;
    logic              r_first, n_first;
    logic              r_last, n_last;
    logic              advance, do_load, fin;
    logic [WORD_W-1:0] load_word;

    always_comb begin
        advance       = !r_ovalid || !i_stall;
        n_state       = r_state;
        n_cur         = r_cur;
        n_pend        = r_pend;
        n_eor         = r_eor;
        n_idx         = r_idx;
        n_row_started = r_row_started;
        n_ovalid      = r_ovalid && i_stall;
        n_word        = r_word;
        n_first       = r_first;
        n_last        = r_last;
        do_load       = 1'b0;
        fin           = 1'b0;
        load_word     = i_rdata;
        o_re          = 1'b0;
        o_raddr       = r_idx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.first.kind != CK_NONE) begin
                        n_cur  = i_req.first;
                        n_pend = i_req.second;
                    end else begin
                        n_cur       = i_req.second;
                        n_pend.kind = CK_NONE;
                        n_pend.len  = i_req.second.len;
                    end
                    n_eor   = (i_req.second.kind != CK_NONE);
                    n_state = S_OP;
                end
            end
            S_OP: begin
                if (advance) begin
                    do_load   = 1'b1;
                    load_word = (r_cur.kind == CK_SKIP) ? i_skip_op : i_run_op;
                    n_state   = S_CNT;
                end
            end
            S_CNT: begin
                if (advance) begin
                    do_load   = 1'b1;
                    load_word = {{(WORD_W-LEN_W){1'b0}}, r_cur.len};
                    if ((r_cur.kind == CK_LIT) && (r_cur.len != '0)) begin
                        o_re    = 1'b1;
                        o_raddr = '0;
                        n_idx   = ONE;
                        n_state = S_LIT;
                    end else begin
                        fin = 1'b1;
                    end
                end
            end
            S_LIT: begin
                if (advance) begin
                    do_load   = 1'b1;
                    load_word = i_rdata;
                    if (r_idx == r_cur.len) begin
                        fin = 1'b1;
                    end else begin
                        o_re  = 1'b1;
                        n_idx = r_idx + ONE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            if (r_pend.kind != CK_NONE) begin
                n_cur       = r_pend;
                n_pend.kind = CK_NONE;
                n_state     = S_OP;
            end else begin
                n_state = S_IDLE;
            end
        end

        if (do_load) begin
            n_ovalid      = 1'b1;
            n_word        = load_word;
            n_first       = !r_row_started;
            n_last        = fin && (r_pend.kind == CK_NONE);
            n_row_started = !(fin && (r_pend.kind == CK_NONE) && r_eor);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_row_started <= 1'b0;
            r_ovalid      <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_row_started <= n_row_started;
            r_ovalid      <= n_ovalid;
        end
        r_cur   <= n_cur;
        r_pend  <= n_pend;
        r_eor   <= n_eor;
        r_idx   <= n_idx;
        r_word  <= n_word;
        r_first <= n_first;
        r_last  <= n_last;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_code_word = r_word;
    assign o_row_first = r_first;
    assign o_last      = r_last;

endmodule

FILE: sv/sprite_skip_run_encoder_top.sv
// ----------------------------------------------------------------------------
// Sprite skip-run encoder
// Codes raster pixels as alternating skip runs and literal runs per row.
// ----------------------------------------------------------------------------
// A pixel that closes no run leaves the input free again in the next cycle.
// A pixel that closes runs holds the input off while the sequencer sends the
// code words, one per cycle when the output is not stalled: two words for a
// skip run and two plus the run length for a literal run, whose pixels are
// read back from the run buffer RAM at one read per cycle. The output
// register lets a new pixel be taken while the last word still waits for
// its transfer. The run buffer needs no clearing after reset, so pixels are
// taken from the first cycle.
// ----------------------------------------------------------------------------
module sprite_skip_run_encoder_top
    import sse_pkg::*;
#(
    parameter int MAX_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [WORD_W-1:0]  i_pixel,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [WORD_W-1:0]  o_code_word,
    output logic               o_row_first,
    output logic               o_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [WORD_W-1:0] r_back_color;
    logic [LEN_W-1:0]  r_row_width;
    logic [WORD_W-1:0] r_skip_op;
    logic [WORD_W-1:0] r_run_op;
    logic              cfg_wr;
    logic [1:0]        cfg_idx;
    logic              busy, accept;
    logic              we, re;
    logic [AW-1:0]     waddr, raddr;
    logic [WORD_W-1:0] wdata, rdata;
    t_flush_req        req;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_back_color <= '0;
            r_row_width  <= ROW_WIDTH_RESET;
            r_skip_op    <= '0;
            r_run_op     <= WORD_W'(1);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_BACK_COLOR: r_back_color <= pwdata[WORD_W-1:0];
                REG_ROW_WIDTH:  r_row_width  <= pwdata[LEN_W-1:0];
                REG_SKIP_OP:    r_skip_op    <= pwdata[WORD_W-1:0];
                REG_RUN_OP:     r_run_op     <= pwdata[WORD_W-1:0];
                default:        r_run_op     <= r_run_op;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_BACK_COLOR: prdata = {{(PDATA_W-WORD_W){1'b0}}, r_back_color};
            REG_ROW_WIDTH:  prdata = {{(PDATA_W-LEN_W){1'b0}}, r_row_width};
            REG_SKIP_OP:    prdata = {{(PDATA_W-WORD_W){1'b0}}, r_skip_op};
            REG_RUN_OP:     prdata = {{(PDATA_W-WORD_W){1'b0}}, r_run_op};
            default:        prdata = '0;
        endcase
    end

    assign o_stall = busy;
    assign accept  = i_valid && !busy;

    sse_run_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_pixel      (i_pixel),
        .i_back_color (r_back_color),
        .i_row_width  (r_row_width),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_req        (req)
    );

    sse_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_run_buf (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    sse_emitter #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_skip_op   (r_skip_op),
        .i_run_op    (r_run_op),
        .i_rdata     (rdata),
        .i_stall     (i_stall),
        .o_busy      (busy),
        .o_re        (re),
        .o_raddr     (raddr),
        .o_valid     (o_valid),
        .o_code_word (o_code_word),
        .o_row_first (o_row_first),
        .o_last      (o_last)
    );

endmodule

FILE: tb/sprite_skip_run_encoder_top_tb.sv
// ----------------------------------------------------------------------------
// Sprite skip-run encoder testbench
// Feeds raster pixels through the encoder under a range of register settings
// and random idling on both sides. A built-in predictor codes every accepted
// pixel transfer into the expected code words, and each output transfer is
// checked field by field against the oldest expected word.
// ----------------------------------------------------------------------------
module sprite_skip_run_encoder_top_tb
    import sse_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W         = 32;
    localparam int BUF_AW        = $clog2(MAX_W);
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_PIXELS  = 37;

    typedef enum logic [1:0] {
        RM_ROW_START,
        RM_SKIP,
        RM_LIT
    } t_run_mode;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              row_first;
        logic              last;
    } t_code_word;

    logic               i_clk    = 1'b0;
    logic               i_rst_n  = 1'b0;
    logic               i_valid  = 1'b0;
    logic               o_stall;
    logic [WORD_W-1:0]  i_pixel  = '0;
    logic               o_valid;
    logic               i_stall  = 1'b0;
    logic [WORD_W-1:0]  o_code_word;
    logic               o_row_first;
    logic               o_last;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr    = '0;
    logic [PDATA_W-1:0] pwdata   = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    sprite_skip_run_encoder_top #(
        .MAX_WIDTH(MAX_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_pixel    (i_pixel),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_code_word(o_code_word),
        .o_row_first(o_row_first),
        .o_last     (o_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state and register copies.
    logic [WORD_W-1:0] cfg_back       = '0;
    logic [LEN_W-1:0]  cfg_row_width  = ROW_WIDTH_RESET;
    logic [WORD_W-1:0] cfg_skip_op    = '0;
    logic [WORD_W-1:0] cfg_run_op     = 16'd1;
    t_run_mode         enc_mode       = RM_ROW_START;
    logic [LEN_W-1:0]  enc_len        = '0;
    logic [LEN_W-1:0]  enc_col        = '0;
    logic              enc_row_begun  = 1'b0;
    logic [WORD_W-1:0] enc_buf [MAX_W];

    t_code_word        step_words[$];
    t_code_word        pending_codes[$];
    logic [WORD_W-1:0] pixel_feed[$];

    bit in_idle  = 1'b0;
    bit out_idle = 1'b0;
    bit pix_xfer = 1'b0;
    bit out_xfer = 1'b0;
    int src_gap  = 0;
    int snk_wait = 0;
    int mismatch_cnt = 0;
    int cycle_cnt    = 0;

    task automatic emit_code(input logic [WORD_W-1:0] w);
        t_code_word c;
        c.word      = w;
        c.row_first = !enc_row_begun;
        c.last      = 1'b0;
        enc_row_begun = 1'b1;
        step_words.push_back(c);
    endtask

    task automatic flush_run();
        if (enc_mode == RM_SKIP) begin
            emit_code(cfg_skip_op);
            emit_code(WORD_W'(enc_len));
        end else if (enc_mode == RM_LIT) begin
            emit_code(cfg_run_op);
            emit_code(WORD_W'(enc_len));
            for (int k = 0; k < int'(enc_len) && k < MAX_W; k++)
                emit_code(enc_buf[k[BUF_AW-1:0]]);
        end
        enc_len = '0;
    endtask

    task automatic encode_pixel(input logic [WORD_W-1:0] pix);
        logic       is_bg;
        int         w;
        t_code_word c;
        is_bg = (pix == cfg_back);
        w = int'(cfg_row_width);
        if (w < 1)
            w = 1;
        if (w > MAX_W)
            w = MAX_W;
        step_words.delete();
        case (enc_mode)
            RM_SKIP: begin
                if (!is_bg) begin
                    flush_run();
                    enc_mode = RM_LIT;
                end
            end
            RM_LIT: begin
                if (is_bg) begin
                    flush_run();
                    enc_mode = RM_SKIP;
                end
            end
            default: begin
                enc_mode = is_bg ? RM_SKIP : RM_LIT;
                enc_len  = '0;
            end
        endcase
        if (enc_mode == RM_LIT && int'(enc_len) < MAX_W)
            enc_buf[enc_len[BUF_AW-1:0]] = pix;
        if (enc_len < LEN_SAT)
            enc_len = enc_len + 1'b1;
        enc_col = enc_col + 1'b1;
        if (int'(enc_col) >= w) begin
            flush_run();
            enc_mode      = RM_ROW_START;
            enc_col       = '0;
            enc_row_begun = 1'b0;
        end
        if (step_words.size() > 0) begin
            c = step_words.pop_back();
            c.last = 1'b1;
            step_words.push_back(c);
        end
        foreach (step_words[i])
            pending_codes.push_back(step_words[i]);
    endtask

    // Pixel driver: acceptance is seen at the rising edge, new payloads go out
    // at the falling edge.
    always @(posedge i_clk) begin
        pix_xfer <= i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall)
            encode_pixel(i_pixel);
    end

    always @(negedge i_clk) begin
        if (i_rst_n && !(i_valid && !pix_xfer)) begin
            if (i_valid)
                src_gap = in_idle ? int'($urandom_range(0, 16)) : 0;
            if (src_gap > 0) begin
                src_gap--;
                i_valid <= 1'b0;
            end else if (pixel_feed.size() > 0) begin
                i_pixel <= pixel_feed.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Code word monitor and receiver stall.
    always @(posedge i_clk) begin
        t_code_word want;
        out_xfer <= i_rst_n && o_valid && !i_stall;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_codes.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected code word %h row_first %b last %b",
                             o_code_word, o_row_first, o_last);
            end else begin
                want = pending_codes.pop_front();
                if (o_code_word !== want.word || o_row_first !== want.row_first ||
                    o_last !== want.last) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("code word mismatch: expected %h/%b/%b, got %h/%b/%b",
                                 want.word, want.row_first, want.last,
                                 o_code_word, o_row_first, o_last);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (out_xfer)
            snk_wait = out_idle ? int'($urandom_range(0, 16)) : 0;
        if (snk_wait > 0) begin
            snk_wait--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[sprite_skip_run_encoder_top] ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [WORD_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_BACK_COLOR: cfg_back      = value;
            REG_ROW_WIDTH:  cfg_row_width = value[LEN_W-1:0];
            REG_SKIP_OP:    cfg_skip_op   = value;
            REG_RUN_OP:     cfg_run_op    = value;
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_regs(input logic [WORD_W-1:0] back, input logic [WORD_W-1:0] width,
                            input logic [WORD_W-1:0] skip_op, input logic [WORD_W-1:0] run_op);
        write_reg(REG_BACK_COLOR, back);
        write_reg(REG_ROW_WIDTH, width);
        write_reg(REG_SKIP_OP, skip_op);
        write_reg(REG_RUN_OP, run_op);
        @(posedge i_clk);
    endtask

    task automatic drain_codes();
        do @(posedge i_clk);
        while (pixel_feed.size() != 0 || i_valid || pending_codes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [WORD_W-1:0] back;
        logic [WORD_W-1:0] width;
        logic [WORD_W-1:0] pix;
        int                fed;
        int                run_n;
        bit                bg_run;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset register values, then a row width cut below the current column.
        pixel_feed.push_back(16'h0000);
        pixel_feed.push_back(16'h1234);
        drain_codes();
        write_reg(REG_ROW_WIDTH, 16'd0);
        @(posedge i_clk);
        pixel_feed.push_back(16'h1234);
        drain_codes();

        // Rows of one pixel with all-ones background and opcodes at the extremes.
        set_regs(16'hFFFF, 16'd1, 16'hFFFF, 16'h0000);
        pixel_feed.push_back(16'hFFFF);
        pixel_feed.push_back(16'h0000);
        pixel_feed.push_back(16'h7FFF);
        drain_codes();

        // Mixed runs, including a pixel that closes a literal and a skip run.
        in_idle  = 1'b1;
        out_idle = 1'b1;
        set_regs(16'h0000, 16'd5, 16'h8000, 16'hFFFF);
        pixel_feed.push_back(16'h0000);
        pixel_feed.push_back(16'h0000);
        pixel_feed.push_back(16'hFFFF);
        pixel_feed.push_back(16'h8001);
        pixel_feed.push_back(16'h0000);
        pixel_feed.push_back(16'h5555);
        pixel_feed.push_back(16'hAAAA);
        pixel_feed.push_back(16'hAAAA);
        pixel_feed.push_back(16'hAAAA);
        pixel_feed.push_back(16'h0000);
        drain_codes();

        // Oversized row width, then narrowed in the middle of a row.
        in_idle  = 1'b0;
        out_idle = 1'b0;
        write_reg(REG_ROW_WIDTH, 16'd63);
        @(posedge i_clk);
        pixel_feed.push_back(16'h0001);
        pixel_feed.push_back(16'h0000);
        pixel_feed.push_back(16'h0000);
        drain_codes();
        write_reg(REG_ROW_WIDTH, 16'd2);
        @(posedge i_clk);
        pixel_feed.push_back(16'h0002);
        drain_codes();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0:       width = 16'd63;
                1:       width = 16'd1;
                2:       width = 16'd32;
                3:       width = 16'd7;
                5:       width = 16'd0;
                7:       width = 16'd3;
                default: width = WORD_W'($urandom_range(0, 63));
            endcase
            case (p % 3)
                0:       back = 16'h0000;
                1:       back = 16'hFFFF;
                default: back = WORD_W'($urandom_range(0, 65535));
            endcase
            if (p == 0)
                set_regs(back, width, 16'hFFFF, 16'h0000);
            else if (p == 4)
                set_regs(back, width, 16'h0000, 16'hFFFF);
            else
                set_regs(back, width, WORD_W'($urandom_range(0, 65535)),
                         WORD_W'($urandom_range(0, 65535)));
            in_idle  = (p % 4 == 1) || (p % 4 == 2);
            out_idle = (p % 4 == 2) || (p % 4 == 3);
            fed = 0;
            while (fed < PHASE_PIXELS) begin
                run_n  = $urandom_range(1, 8);
                bg_run = 1'($urandom_range(0, 1));
                for (int k = 0; k < run_n && fed < PHASE_PIXELS; k++) begin
                    if ($urandom_range(0, 7) == 0 || !bg_run)
                        pix = WORD_W'($urandom_range(0, 65535));
                    else
                        pix = back;
                    pixel_feed.push_back(pix);
                    fed++;
                end
            end
            drain_codes();
        end

        if (mismatch_cnt == 0)
            $display("[sprite_skip_run_encoder_top] OK");
        else
            $display("[sprite_skip_run_encoder_top] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
sv/sse_pkg.sv
sv/sse_ram.sv
sv/sse_run_ctrl.sv
sv/sse_emitter.sv
sv/sprite_skip_run_encoder_top.sv
tb/sprite_skip_run_encoder_top_tb.sv
